// ===== design/cdt_pkg.sv =====
// shared types, widths, codes and helper functions of the countdown timer
package cdt_pkg;

    localparam int TICK_W     = 10;
    localparam int MIN_W      = 7;
    localparam int SEC_W      = 6;
    localparam int PCT_W      = 7;
    localparam int TOT_W      = 13;
    localparam int NUM_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    typedef logic [TICK_W-1:0] tick_t;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_MINUTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SECONDS = 2'd1;

    localparam logic [SEC_W:0]   SEC_WRAP   = 7'd60;
    localparam logic [SEC_W-1:0] SEC_LAST   = 6'd59;
    localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
    localparam logic [TOT_W-1:0] SEC_PER_MIN = 13'd60;
    localparam logic [NUM_W-1:0] PCT_SCALE  = 20'd100;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PREP  = 5'b00010,
        ST_START = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // tens digit by reciprocal multiply, exact for every 7-bit input (0 to 127)
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] ones_of(input logic [6:0] v, input logic [3:0] tens);
        logic [6:0] t10;
        t10 = 7'(tens) * 7'd10;
        return 4'(v - t10);
    endfunction

endpackage

// ===== design/cdt_div.sv =====
// restoring divider, one quotient bit per cycle
module cdt_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cdt_pkg::NUM_W-1:0] num,
    input  logic [cdt_pkg::TOT_W-1:0] den,
    output cdt_pkg::div_stat_t        stat,
    output logic [cdt_pkg::NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(cdt_pkg::NUM_W + 1);

    logic [cdt_pkg::TOT_W-1:0] rem_reg, rem_next;
    logic [cdt_pkg::NUM_W-1:0] acc_reg, acc_next;
    logic [cdt_pkg::TOT_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    logic [cdt_pkg::TOT_W:0] trial;
    logic [cdt_pkg::TOT_W:0] diff;
    logic                    ge;

    assign trial = {rem_reg, acc_reg[cdt_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            acc_next  = num;
            den_next  = den;
            cnt_next  = CNT_W'(cdt_pkg::NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[cdt_pkg::TOT_W-1:0] : trial[cdt_pkg::TOT_W-1:0];
            acc_next = {acc_reg[cdt_pkg::NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = acc_reg;

endmodule

// ===== design/countdown_timer_with_progress.sv =====
// top level: tick-driven minutes:seconds countdown with percent left and colon
//
// each transfer on the s_ channel is one tick; s_run lets it advance the
// prescaler. every tick gives exactly one result on the m_ channel.
// total minutes and seconds are written through the cfg_ channel (index 0
// minutes, index 1 seconds); the user must write them only while no tick is
// in flight, which the block itself does not enforce; cfg_ready is always high.
// an ordinary tick goes to the done state and its result is loaded into the
// output register once that is free, after which the next tick is taken.
// the half-second tick that recomputes the remaining time forms the remaining
// and configured totals in seconds, loads the bit-serial divider (20 quotient
// bits at one per cycle) and takes the quotient; a zero total skips the divider.
// one tick is worked on at a time; the next tick is taken as soon as the
// block is back to idle, even while the previous result still sits in the
// output register. a stalled receiver holds the result and, once the next
// tick is done, holds that tick in the block until the output register frees.
// reset (aresetn low, synchronous) clears the counters and configured totals,
// sets up 00:00 with 100 percent and the colon on, and empties the output register.
module countdown_timer_with_progress #(
    parameter int TICKS_PER_SEC = 30
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_run,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_updated,
    output logic [3:0]                     m_min_tens,
    output logic [3:0]                     m_min_ones,
    output logic [2:0]                     m_sec_tens,
    output logic [3:0]                     m_sec_ones,
    output logic [cdt_pkg::PCT_W-1:0]      m_percent_left,
    output logic                           m_colon_on,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cdt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdt_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam cdt_pkg::tick_t HALF_TICK = cdt_pkg::tick_t'(TICKS_PER_SEC / 2);
    localparam cdt_pkg::tick_t FULL_TICK = cdt_pkg::tick_t'(TICKS_PER_SEC);

    cdt_pkg::state_t state_reg, state_next;

    logic [cdt_pkg::MIN_W-1:0] tm_reg, tm_next;
    logic [cdt_pkg::SEC_W-1:0] ts_reg, ts_next;

    cdt_pkg::tick_t            tick_reg, tick_next;
    logic [cdt_pkg::SEC_W-1:0] sec_reg, sec_next;
    logic [cdt_pkg::MIN_W-1:0] min_reg, min_next;
    logic                      fmd_reg, fmd_next;
    logic [cdt_pkg::MIN_W-1:0] shown_min_reg, shown_min_next;
    logic [cdt_pkg::SEC_W-1:0] shown_sec_reg, shown_sec_next;
    logic [cdt_pkg::PCT_W-1:0] pct_reg, pct_next;
    logic                      colon_reg, colon_next;
    logic                      upd_reg, upd_next;

    logic [cdt_pkg::TOT_W-1:0] tot_reg, tot_next;
    logic [cdt_pkg::TOT_W-1:0] den_reg, den_next;

    logic                      m_valid_reg, m_valid_next;
    logic                      m_updated_reg;
    logic [3:0]                m_min_tens_reg, m_min_ones_reg, m_sec_ones_reg;
    logic [2:0]                m_sec_tens_reg;
    logic [cdt_pkg::PCT_W-1:0] m_pct_reg;
    logic                      m_colon_reg;
    logic                      out_load;

    logic                      div_start;
    cdt_pkg::div_stat_t        div_stat;
    logic [cdt_pkg::NUM_W-1:0] div_quo;

    logic                      s_xfer;
    cdt_pkg::tick_t            tick_inc;
    logic [cdt_pkg::SEC_W:0]   sec_inc, ts_inc;
    logic                      wrap;
    logic [cdt_pkg::SEC_W-1:0] sec_new;
    logic [cdt_pkg::MIN_W-1:0] min_new;
    logic                      fmd_new;
    logic [3:0]                min_tens, sec_tens4;

    assign s_ready   = (state_reg == cdt_pkg::ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_comb begin
        tm_next = tm_reg;
        ts_next = ts_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == cdt_pkg::REG_TOTAL_MINUTES) begin
                tm_next = cfg_data[cdt_pkg::MIN_W-1:0];
            end else if (cfg_index == cdt_pkg::REG_TOTAL_SECONDS) begin
                ts_next = cfg_data[cdt_pkg::SEC_W-1:0];
            end
        end
    end

    // half-second step of the second and minute counters
    assign tick_inc = tick_reg + 1'b1;
    assign sec_inc  = {1'b0, sec_reg} + 1'b1;
    assign ts_inc   = {1'b0, ts_reg} + 1'b1;
    assign wrap     = (sec_inc == cdt_pkg::SEC_WRAP) || ((sec_inc == ts_inc) && !fmd_reg);

    always_comb begin
        sec_new = sec_inc[cdt_pkg::SEC_W-1:0];
        min_new = min_reg;
        fmd_new = fmd_reg;
        if (wrap) begin
            if (sec_inc == ts_inc) begin
                fmd_new = 1'b1;
            end
            sec_new = '0;
            if (min_reg == tm_reg) begin
                min_new = '0;
                fmd_new = 1'b0;
            end else begin
                min_new = min_reg + 1'b1;
            end
        end
    end

    assign min_tens  = cdt_pkg::tens_of(shown_min_reg);
    assign sec_tens4 = cdt_pkg::tens_of({1'b0, shown_sec_reg});
    assign out_load  = (state_reg == cdt_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        fmd_next       = fmd_reg;
        shown_min_next = shown_min_reg;
        shown_sec_next = shown_sec_reg;
        pct_next       = pct_reg;
        colon_next     = colon_reg;
        upd_next       = upd_reg;
        tot_next       = tot_reg;
        den_next       = den_reg;
        div_start      = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        case (state_reg)
            cdt_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    upd_next   = 1'b0;
                    state_next = cdt_pkg::ST_DONE;
                    if (s_run) begin
                        tick_next = tick_inc;
                        if (tick_inc == HALF_TICK) begin
                            upd_next   = 1'b1;
                            sec_next   = sec_new;
                            min_next   = min_new;
                            fmd_next   = fmd_new;
                            colon_next = 1'b0;
                            shown_min_next = (tm_reg >= min_new) ? tm_reg - min_new : '0;
                            if (fmd_new) begin
                                shown_sec_next = cdt_pkg::SEC_LAST - sec_new;
                            end else begin
                                shown_sec_next = (ts_reg >= sec_new) ? ts_reg - sec_new : '0;
                            end
                            state_next = cdt_pkg::ST_PREP;
                        end else if (tick_inc == FULL_TICK) begin
                            tick_next  = '0;
                            colon_next = 1'b1;
                        end
                    end
                end
            end
            cdt_pkg::ST_PREP: begin
                tot_next = cdt_pkg::TOT_W'(shown_min_reg) * cdt_pkg::SEC_PER_MIN
                         + cdt_pkg::TOT_W'(shown_sec_reg);
                den_next = cdt_pkg::TOT_W'(tm_reg) * cdt_pkg::SEC_PER_MIN
                         + cdt_pkg::TOT_W'(ts_reg);
                state_next = cdt_pkg::ST_START;
            end
            cdt_pkg::ST_START: begin
                if (den_reg == '0) begin
                    pct_next   = '0;
                    state_next = cdt_pkg::ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = cdt_pkg::ST_DIV;
                end
            end
            cdt_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    pct_next = (div_quo > cdt_pkg::NUM_W'(cdt_pkg::PCT_FULL))
                             ? cdt_pkg::PCT_FULL : div_quo[cdt_pkg::PCT_W-1:0];
                    state_next = cdt_pkg::ST_DONE;
                end
            end
            cdt_pkg::ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = cdt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cdt_pkg::ST_IDLE;
            end
        endcase
    end

    cdt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (cdt_pkg::NUM_W'(tot_reg) * cdt_pkg::PCT_SCALE),
        .den     (den_reg),
        .stat    (div_stat),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cdt_pkg::ST_IDLE;
            tm_reg        <= '0;
            ts_reg        <= '0;
            tick_reg      <= '0;
            sec_reg       <= '0;
            min_reg       <= '0;
            fmd_reg       <= 1'b0;
            shown_min_reg <= '0;
            shown_sec_reg <= '0;
            pct_reg       <= cdt_pkg::PCT_FULL;
            colon_reg     <= 1'b1;
            upd_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tm_reg        <= tm_next;
            ts_reg        <= ts_next;
            tick_reg      <= tick_next;
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            fmd_reg       <= fmd_next;
            shown_min_reg <= shown_min_next;
            shown_sec_reg <= shown_sec_next;
            pct_reg       <= pct_next;
            colon_reg     <= colon_next;
            upd_reg       <= upd_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tot_reg <= tot_next;
        den_reg <= den_next;
        if (out_load) begin
            m_updated_reg  <= upd_reg;
            m_min_tens_reg <= min_tens;
            m_min_ones_reg <= cdt_pkg::ones_of(shown_min_reg, min_tens);
            m_sec_tens_reg <= sec_tens4[2:0];
            m_sec_ones_reg <= cdt_pkg::ones_of({1'b0, shown_sec_reg}, sec_tens4);
            m_pct_reg      <= pct_reg;
            m_colon_reg    <= colon_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_updated      = m_updated_reg;
    assign m_min_tens     = m_min_tens_reg;
    assign m_min_ones     = m_min_ones_reg;
    assign m_sec_tens     = m_sec_tens_reg;
    assign m_sec_ones     = m_sec_ones_reg;
    assign m_percent_left = m_pct_reg;
    assign m_colon_on     = m_colon_reg;

`ifndef SYNTH
    // divider completion only arrives while waiting for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == cdt_pkg::ST_DIV))
        else $error("divider done outside divide state");

    // divider is only started when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // prescaler never rests at or beyond a full second
    assert property (@(posedge aclk) disable iff (!aresetn)
        tick_reg < FULL_TICK)
        else $error("prescaler out of range");

    // percentage never rises above full
    assert property (@(posedge aclk) disable iff (!aresetn)
        pct_reg <= cdt_pkg::PCT_FULL)
        else $error("percentage above full");

    // a recomputing tick always reports the colon hidden
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_updated) |-> !m_colon_on)
        else $error("colon shown on update result");
`endif

endmodule
